[design/bed_pkg.sv]
// package for the button event detector: types, codes and constants
package bed_pkg;

  localparam int unsigned LevelWidth   = 1;
  localparam int unsigned MsWidth      = 8;
  localparam int unsigned FlagWidth    = 7;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned TimeWidth    = 16;
  localparam int unsigned DebWidth     = 8;
  localparam int unsigned ModeWidth    = 2;

  localparam logic [TimeWidth-1:0] TimerMax  = 16'hFFFF;
  localparam logic [DebWidth-1:0]  DebReset  = 8'd2;

  // event flag bit positions
  localparam int unsigned EvPress   = 0;
  localparam int unsigned EvRelease = 1;
  localparam int unsigned EvClick   = 2;
  localparam int unsigned EvDouble  = 3;
  localparam int unsigned EvRepeat  = 4;
  localparam int unsigned EvShort   = 5;
  localparam int unsigned EvLong    = 6;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ACTIVE_LEVEL  = 3'd0,
    CFG_DEBOUNCE      = 3'd1,
    CFG_PRESS_MODE    = 3'd2,
    CFG_TRIG_RELEASE  = 3'd3,
    CFG_FIRST_TIME    = 3'd4,
    CFG_SECOND_TIME   = 3'd5,
    CFG_MAX_REPEATS   = 3'd6,
    CFG_DCLICK_WINDOW = 3'd7
  } cfg_idx_e;

  typedef enum logic [ModeWidth-1:0] {
    MODE_SINGLE = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_LONG   = 2'd2,
    MODE_BAD    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_WAIT     = 4'd0,
    ST_DEBOUNCE = 4'd1,
    ST_PRESSED  = 4'd2,
    ST_M0       = 4'd3,
    ST_M1_FIRST = 4'd4,
    ST_M1_DELAY = 4'd5,
    ST_M1_RUN   = 4'd6,
    ST_M2_SHORT = 4'd7,
    ST_M2_LONG  = 4'd8,
    ST_HOLD     = 4'd9
  } state_e;

  typedef struct packed {
    logic                 active_level;
    logic [DebWidth-1:0]  debounce_ticks;
    mode_e                press_mode;
    logic                 trigger_on_release;
    logic [TimeWidth-1:0] first_time;
    logic [TimeWidth-1:0] second_time;
    logic [TimeWidth-1:0] max_repeats;
    logic [TimeWidth-1:0] double_click_window;
  } cfg_t;

endpackage

[design/bed_if.sv]
// handshake interfaces for scan words, event words and register writes
interface bed_scan_if;
  import bed_pkg::*;
  logic               valid;
  logic               ready;
  logic               button_level;
  logic [MsWidth-1:0] elapsed_ms;
  modport source (output valid, button_level, elapsed_ms, input ready);
  modport sink   (input valid, button_level, elapsed_ms, output ready);
endinterface

interface bed_event_if;
  import bed_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FlagWidth-1:0] event_flags;
  modport source (output valid, event_flags, input ready);
  modport sink   (input valid, event_flags, output ready);
endinterface

interface bed_cfg_if;
  import bed_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/bed_cfg_regs.sv]
// configuration register file
module bed_cfg_regs
  import bed_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bed_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ACTIVE_LEVEL:  cfg_d.active_level = cfg_i.data[0];
        CFG_DEBOUNCE:      cfg_d.debounce_ticks = cfg_i.data[DebWidth-1:0];
        CFG_PRESS_MODE: begin
          // reserved mode code is ignored
          if (mode_e'(cfg_i.data[ModeWidth-1:0]) != MODE_BAD) begin
            cfg_d.press_mode = mode_e'(cfg_i.data[ModeWidth-1:0]);
          end
        end
        CFG_TRIG_RELEASE:  cfg_d.trigger_on_release = cfg_i.data[0];
        CFG_FIRST_TIME:    cfg_d.first_time = cfg_i.data[TimeWidth-1:0];
        CFG_SECOND_TIME:   cfg_d.second_time = cfg_i.data[TimeWidth-1:0];
        CFG_MAX_REPEATS:   cfg_d.max_repeats = cfg_i.data[TimeWidth-1:0];
        CFG_DCLICK_WINDOW: cfg_d.double_click_window = cfg_i.data[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{active_level: 1'b0, debounce_ticks: DebReset, press_mode: MODE_SINGLE,
                 trigger_on_release: 1'b0, first_time: '0, second_time: '0,
                 max_repeats: '0, double_click_window: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/bed_core.sv]
// press state machine, timer and repeat counter with per-tick event logic
module bed_core
  import bed_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 button_level_i,
  input  logic [MsWidth-1:0]   elapsed_ms_i,
  input  cfg_t                 cfg_i,
  output logic [FlagWidth-1:0] flags_o
);

  state_e               state_q, state_d;
  logic [TimeWidth-1:0] timer_q, timer_d;
  logic [DebWidth-1:0]  deb_q, deb_d;
  logic [TimeWidth-1:0] last_q, last_d;
  logic [TimeWidth-1:0] rcount_q, rcount_d;
  logic                 defer_q, defer_d;

  logic                 pressed;
  logic [TimeWidth:0]   timer_sum;
  logic [TimeWidth-1:0] timer_adv;
  logic [TimeWidth-1:0] gap;
  logic [7:0]           dmin, dmax;
  logic [FlagWidth-1:0] ev;

  assign pressed   = (button_level_i == cfg_i.active_level);
  assign timer_sum = {1'b0, timer_q} + {{(TimeWidth+1-MsWidth){1'b0}}, elapsed_ms_i};
  assign timer_adv = (timer_q == TimerMax) ? timer_q
                   : (timer_sum[TimeWidth] ? TimerMax : timer_sum[TimeWidth-1:0]);
  assign gap       = (timer_adv >= last_q) ? (timer_adv - last_q) : '0;
  assign dmin      = cfg_i.double_click_window[7:0];
  assign dmax      = cfg_i.double_click_window[15:8];

  function automatic logic defer_after_step(state_e st, logic d, cfg_t c);
    logic r;
    r = d;
    if (st == ST_M0 && c.trigger_on_release) r = 1'b1;
    if (st == ST_M2_SHORT && timer_adv >= c.first_time && c.trigger_on_release) r = 1'b1;
    if (st == ST_M2_LONG && timer_adv >= c.second_time) r = 1'b0;
    return r;
  endfunction

  // next state
  always_comb begin
    state_d  = state_q;
    timer_d  = timer_adv;
    deb_d    = deb_q;
    last_d   = last_q;
    rcount_d = rcount_q;
    defer_d  = defer_q;
    unique case (state_q)
      ST_WAIT: begin
        if (pressed) begin
          state_d = ST_DEBOUNCE;
          deb_d   = cfg_i.debounce_ticks;
        end
      end
      ST_DEBOUNCE: begin
        deb_d = deb_q - 1'b1;
        if (deb_q == DebWidth'(1)) state_d = ST_PRESSED;
      end
      ST_PRESSED: begin
        timer_d = '0;
        unique case (cfg_i.press_mode)
          MODE_REPEAT: state_d = ST_M1_FIRST;
          MODE_LONG:   state_d = ST_M2_SHORT;
          default:     state_d = ST_M0;
        endcase
      end
      ST_M0: begin
        state_d = ST_HOLD;
        if (cfg_i.trigger_on_release) defer_d = 1'b1;
      end
      ST_M1_FIRST: state_d = ST_M1_DELAY;
      ST_M1_DELAY: begin
        if (timer_adv > cfg_i.first_time) state_d = ST_M1_RUN;
      end
      ST_M1_RUN: begin
        if (rcount_q < cfg_i.max_repeats || cfg_i.max_repeats == '0) begin
          if (gap >= cfg_i.second_time) begin
            if (rcount_q != TimerMax) rcount_d = rcount_q + 1'b1;
            last_d = timer_adv;
          end
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_M2_SHORT: begin
        if (timer_adv >= cfg_i.first_time) begin
          state_d = (cfg_i.second_time != '0) ? ST_M2_LONG : ST_HOLD;
          if (cfg_i.trigger_on_release) defer_d = 1'b1;
        end
      end
      ST_M2_LONG: begin
        if (timer_adv >= cfg_i.second_time) begin
          defer_d = 1'b0;
          state_d = ST_HOLD;
        end
      end
      default: ;
    endcase
    // release check
    if (!pressed && state_d != ST_WAIT) begin
      if (cfg_i.press_mode == MODE_REPEAT) rcount_d = '0;
      defer_d = 1'b0;
      state_d = ST_WAIT;
      last_d  = '0;
      timer_d = TimeWidth'(1);
    end
  end

  // event flags
  always_comb begin
    ev = '0;
    unique case (state_q)
      ST_WAIT: ev[EvPress] = pressed;
      ST_PRESSED: begin
        ev[EvDouble] = (dmin != '0) && (timer_adv < {8'd0, dmax}) && (timer_adv > {8'd0, dmin});
      end
      ST_M0: ev[EvClick] = !cfg_i.trigger_on_release;
      ST_M1_FIRST: ev[EvClick] = 1'b1;
      ST_M1_RUN: begin
        ev[EvRepeat] = (rcount_q < cfg_i.max_repeats || cfg_i.max_repeats == '0)
                     && (gap >= cfg_i.second_time);
      end
      ST_M2_SHORT: begin
        ev[EvShort] = (timer_adv >= cfg_i.first_time) && !cfg_i.trigger_on_release;
      end
      ST_M2_LONG: ev[EvLong] = (timer_adv >= cfg_i.second_time);
      default: ;
    endcase
    if (!pressed && state_d == ST_WAIT && !(state_q == ST_WAIT)) begin
      ev[EvRelease] = 1'b1;
    end
    // deferred event as it stands after this tick's step
    if (!pressed && state_q != ST_WAIT) begin
      unique case (cfg_i.press_mode)
        MODE_SINGLE: ev[EvClick] = ev[EvClick] | defer_after_step(state_q, defer_q, cfg_i);
        MODE_LONG:   ev[EvShort] = ev[EvShort] | defer_after_step(state_q, defer_q, cfg_i);
        default: ;
      endcase
    end
    flags_o = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WAIT;
      timer_q  <= TimerMax;
      deb_q    <= '0;
      last_q   <= '0;
      rcount_q <= '0;
      defer_q  <= 1'b0;
    end else if (step_i) begin
      state_q  <= state_d;
      timer_q  <= timer_d;
      deb_q    <= deb_d;
      last_q   <= last_d;
      rcount_q <= rcount_d;
      defer_q  <= defer_d;
    end
  end

endmodule

[design/button_event_detector.sv]
// Button event detector top level. Each scan word (raw level and elapsed
// milliseconds) is registered, stepped through the press state machine
// combinationally and its 7-bit event word lands in a result register: one
// word per cycle sustained while the event output is not stalled, each word
// passing the input register and then the result register. A new scan
// word is taken whenever the input register is empty or moves on, which it
// does while the result register is empty or being drained. Every scan word
// gives exactly one event word. Register writes take effect at once and are
// expected only while no word is in flight.
module button_event_detector
  import bed_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  bed_scan_if.sink     scan_i,
  bed_event_if.source  event_o,
  bed_cfg_if.sink      cfg_i
);

  cfg_t                 cfg;
  logic                 in_valid_q;
  logic                 level_q;
  logic [MsWidth-1:0]   ms_q;
  logic                 out_valid_q;
  logic [FlagWidth-1:0] flags_q;
  logic [FlagWidth-1:0] flags;
  logic                 advance;
  logic                 take;

  assign advance       = in_valid_q && (!out_valid_q || event_o.ready);
  assign scan_i.ready  = !in_valid_q || advance;
  assign take          = scan_i.valid && scan_i.ready;
  assign event_o.valid = out_valid_q;
  assign event_o.event_flags = flags_q;

  bed_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bed_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .button_level_i (level_q),
    .elapsed_ms_i   (ms_q),
    .cfg_i          (cfg),
    .flags_o        (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (event_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      level_q <= scan_i.button_level;
      ms_q    <= scan_i.elapsed_ms;
    end
    if (advance) begin
      flags_q <= flags;
    end
  end

endmodule

[verif/button_event_detector_tb.sv]
// testbench for button_event_detector: directed scan table, random press phases, event checks
module button_event_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bed_pkg::*;

  localparam int unsigned NumDirRows = 40;
  localparam bit Wr = 1'b1;
  localparam bit Sc = 1'b0;

  localparam logic [FlagWidth-1:0] NoFlags  = '0;
  localparam logic [FlagWidth-1:0] FPress   = FlagWidth'(1 << EvPress);
  localparam logic [FlagWidth-1:0] FRelease = FlagWidth'(1 << EvRelease);
  localparam logic [FlagWidth-1:0] FClick   = FlagWidth'(1 << EvClick);

  typedef struct {
    bit                      is_write;
    cfg_idx_e                reg_idx;
    logic [CfgDataWidth-1:0] reg_val;
    logic                    lvl;
    logic [MsWidth-1:0]      ms;
    bit                      typed;
    logic [FlagWidth-1:0]    flags;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   idle_on = 1'b1;

  logic                 row_typed;
  logic [FlagWidth-1:0] row_flags;
  logic [FlagWidth-1:0] flags_due [$];
  logic [FlagWidth-1:0] wanted;
  logic [FlagWidth-1:0] predicted;
  int unsigned          scans_sent = 0;
  int unsigned          mismatches = 0;

  // mirror of the press tracker
  cfg_t                 shadow_cfg;
  state_e               scan_st;
  logic [TimeWidth-1:0] press_time;
  logic [TimeWidth-1:0] last_rep_time;
  logic [TimeWidth-1:0] rep_cnt;
  logic [DebWidth-1:0]  deb_cnt;
  logic                 held_event;

  dir_row_t dir_rows [NumDirRows] = '{
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd255, 1'b1, FPress},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd0,   1'b1, FClick},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd255, 1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd255, 1'b1, FRelease},
    '{Wr, CFG_ACTIVE_LEVEL, 16'h0001, 1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_DEBOUNCE,     16'h0001, 1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_PRESS_MODE,   16'(MODE_BAD), 1'b0, 8'd0, 1'b0, NoFlags},
    '{Wr, CFG_TRIG_RELEASE, 16'h0001, 1'b0, 8'd0,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd0,   1'b1, FPress},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd0,   1'b1, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd7,   1'b1, FClick | FRelease},
    '{Wr, CFG_PRESS_MODE,   16'(MODE_LONG), 1'b0, 8'd0, 1'b0, NoFlags},
    '{Wr, CFG_TRIG_RELEASE, 16'h0000, 1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_DCLICK_WINDOW, 16'hC805, 1'b0, 8'd0,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd10,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd10,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd10,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd0,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_PRESS_MODE,   16'(MODE_REPEAT), 1'b0, 8'd0, 1'b0, NoFlags},
    '{Wr, CFG_FIRST_TIME,   16'd5,    1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_SECOND_TIME,  16'd3,    1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_MAX_REPEATS,  16'd2,    1'b0, 8'd0,   1'b0, NoFlags},
    '{Wr, CFG_DCLICK_WINDOW, 16'h0000, 1'b0, 8'd0,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd1,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd1,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd1,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd1,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd10,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd10,  1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd1,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd5,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b1, 8'd5,   1'b0, NoFlags},
    '{Sc, CFG_ACTIVE_LEVEL, 16'h0000, 1'b0, 8'd1,   1'b0, NoFlags}
  };

  bed_scan_if  scan_if();
  bed_event_if event_if();
  bed_cfg_if   cfg_if();

  button_event_detector DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (scan_if),
    .event_o (event_if),
    .cfg_i   (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    event_if.ready <= !idle_on || ($urandom_range(0, 99) >= 8);
  end

  function automatic logic [FlagWidth-1:0] scan_events(input logic lvl,
                                                        input logic [MsWidth-1:0] ms);
    logic [FlagWidth-1:0] ev;
    logic                 pressed;
    logic [TimeWidth:0]   sum;
    logic [TimeWidth-1:0] gap;
    ev = '0;
    pressed = (lvl == shadow_cfg.active_level);
    if (press_time != TimerMax) begin
      sum = {1'b0, press_time} + {{(TimeWidth + 1 - MsWidth){1'b0}}, ms};
      press_time = sum[TimeWidth] ? TimerMax : sum[TimeWidth-1:0];
    end
    case (scan_st)
      ST_WAIT: begin
        if (pressed) begin
          scan_st = ST_DEBOUNCE;
          deb_cnt = shadow_cfg.debounce_ticks;
          ev[EvPress] = 1'b1;
        end
      end
      ST_DEBOUNCE: begin
        deb_cnt = deb_cnt - 1'b1;
        if (deb_cnt == '0) scan_st = ST_PRESSED;
      end
      ST_PRESSED: begin
        if (shadow_cfg.double_click_window[7:0] != '0 &&
            press_time < shadow_cfg.double_click_window[15:8] &&
            press_time > shadow_cfg.double_click_window[7:0]) ev[EvDouble] = 1'b1;
        press_time = '0;
        case (shadow_cfg.press_mode)
          MODE_REPEAT: scan_st = ST_M1_FIRST;
          MODE_LONG:   scan_st = ST_M2_SHORT;
          default:     scan_st = ST_M0;
        endcase
      end
      ST_M0: begin
        scan_st = ST_HOLD;
        if (!shadow_cfg.trigger_on_release) ev[EvClick] = 1'b1;
        else held_event = 1'b1;
      end
      ST_M1_FIRST: begin
        scan_st = ST_M1_DELAY;
        ev[EvClick] = 1'b1;
      end
      ST_M1_DELAY: begin
        if (press_time > shadow_cfg.first_time) scan_st = ST_M1_RUN;
      end
      ST_M1_RUN: begin
        if (rep_cnt < shadow_cfg.max_repeats || shadow_cfg.max_repeats == '0) begin
          gap = (press_time >= last_rep_time) ? press_time - last_rep_time : '0;
          if (gap >= shadow_cfg.second_time) begin
            if (rep_cnt != TimerMax) rep_cnt = rep_cnt + 1'b1;
            last_rep_time = press_time;
            ev[EvRepeat] = 1'b1;
          end
        end else begin
          scan_st = ST_HOLD;
        end
      end
      ST_M2_SHORT: begin
        if (press_time >= shadow_cfg.first_time) begin
          scan_st = (shadow_cfg.second_time != '0) ? ST_M2_LONG : ST_HOLD;
          if (!shadow_cfg.trigger_on_release) ev[EvShort] = 1'b1;
          else held_event = 1'b1;
        end
      end
      ST_M2_LONG: begin
        if (press_time >= shadow_cfg.second_time) begin
          held_event = 1'b0;
          ev[EvLong] = 1'b1;
          scan_st = ST_HOLD;
        end
      end
      default: ;
    endcase
    if (!pressed && scan_st != ST_WAIT) begin
      case (shadow_cfg.press_mode)
        MODE_SINGLE: if (held_event) ev[EvClick] = 1'b1;
        MODE_REPEAT: rep_cnt = '0;
        default:     if (held_event) ev[EvShort] = 1'b1;
      endcase
      held_event = 1'b0;
      ev[EvRelease] = 1'b1;
      scan_st = ST_WAIT;
      last_rep_time = '0;
      press_time = 16'd1;
    end
    return ev;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (event_if.valid && event_if.ready) begin
        if (flags_due.size() == 0) begin
          $display("%0t: event word with nothing pending: expected none, actual %h",
                   $time, event_if.event_flags);
          mismatches++;
        end else begin
          wanted = flags_due.pop_front();
          if (event_if.event_flags !== wanted) begin
            $display("%0t: event_flags mismatch: expected %h, actual %h",
                     $time, wanted, event_if.event_flags);
            mismatches++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          CFG_ACTIVE_LEVEL:  shadow_cfg.active_level = cfg_if.data[0];
          CFG_DEBOUNCE:      shadow_cfg.debounce_ticks = cfg_if.data[DebWidth-1:0];
          CFG_PRESS_MODE: begin
            if (cfg_if.data[ModeWidth-1:0] != MODE_BAD)
              shadow_cfg.press_mode = mode_e'(cfg_if.data[ModeWidth-1:0]);
          end
          CFG_TRIG_RELEASE:  shadow_cfg.trigger_on_release = cfg_if.data[0];
          CFG_FIRST_TIME:    shadow_cfg.first_time = cfg_if.data;
          CFG_SECOND_TIME:   shadow_cfg.second_time = cfg_if.data;
          CFG_MAX_REPEATS:   shadow_cfg.max_repeats = cfg_if.data;
          CFG_DCLICK_WINDOW: shadow_cfg.double_click_window = cfg_if.data;
          default: ;
        endcase
      end
      if (scan_if.valid && scan_if.ready) begin
        predicted = scan_events(scan_if.button_level, scan_if.elapsed_ms);
        flags_due.push_back(row_typed ? row_flags : predicted);
      end
    end
  end

  function automatic logic [MsWidth-1:0] pick_ms(input int lo, input int hi);
    if ($urandom_range(0, 15) == 0) return MsWidth'($urandom);
    return MsWidth'($urandom_range(lo, hi));
  endfunction

  task automatic send_scan(input logic lvl, input logic [MsWidth-1:0] ms, input logic typed,
                           input logic [FlagWidth-1:0] flags);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      scan_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    scan_if.valid        <= 1'b1;
    scan_if.button_level <= lvl;
    scan_if.elapsed_ms   <= ms;
    row_typed            <= typed;
    row_flags            <= flags;
    @(posedge clk_i);
    while (!scan_if.ready) @(posedge clk_i);
    scans_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    scan_if.valid <= 1'b0;
    while (flags_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataWidth-1:0] val);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_words, input int hold_min, input int hold_max,
                           input int ms_lo, input int ms_hi);
    int unsigned stop_at;
    int          len;
    int          deb_len;
    int          r;
    logic        act;
    stop_at = scans_sent + n_words;
    act = shadow_cfg.active_level;
    deb_len = (shadow_cfg.debounce_ticks == '0) ? 256 : shadow_cfg.debounce_ticks;
    while (scans_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        len = $urandom_range(1, 4);
        repeat (len) send_scan(1'($urandom), pick_ms(ms_lo, ms_hi), 1'b0, NoFlags);
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_scan(!act, pick_ms(ms_lo, ms_hi), 1'b0, NoFlags);
        // bounce: released before or just after debounce ends
        if (r < 22) len = $urandom_range(1, deb_len + 2);
        else len = deb_len + $urandom_range(hold_min, hold_max);
        repeat (len) send_scan(act, pick_ms(ms_lo, ms_hi), 1'b0, NoFlags);
      end
    end
  endtask

  initial begin
    logic                 al;
    logic                 trig;
    logic [DebWidth-1:0]  deb;
    logic [ModeWidth-1:0] mode;
    logic [TimeWidth-1:0] first_t;
    logic [TimeWidth-1:0] second_t;
    logic [TimeWidth-1:0] max_r;
    logic [TimeWidth-1:0] dcw;
    int                   n_words;
    int                   hold_min;
    int                   hold_max;
    int                   ms_lo;
    int                   ms_hi;
    scan_if.valid        = 1'b0;
    scan_if.button_level = 1'b0;
    scan_if.elapsed_ms   = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_ACTIVE_LEVEL;
    cfg_if.data          = '0;
    event_if.ready       = 1'b0;
    row_typed            = 1'b0;
    row_flags            = NoFlags;
    shadow_cfg           = '0;
    shadow_cfg.debounce_ticks = DebReset;
    shadow_cfg.press_mode     = MODE_SINGLE;
    scan_st       = ST_WAIT;
    press_time    = TimerMax;
    deb_cnt       = '0;
    last_rep_time = '0;
    rep_cnt       = '0;
    held_event    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_scan(dir_rows[i].lvl, dir_rows[i].ms, dir_rows[i].typed, dir_rows[i].flags);
    end

    for (int p = 0; p < 10; p++) begin
      al       = 1'($urandom);
      trig     = 1'($urandom);
      deb      = DebWidth'($urandom_range(1, 4));
      mode     = ModeWidth'($urandom_range(0, 2));
      first_t  = TimeWidth'($urandom_range(0, 60));
      second_t = TimeWidth'($urandom_range(0, 40));
      max_r    = TimeWidth'($urandom_range(0, 5));
      dcw      = {8'($urandom_range(20, 120)), 8'($urandom_range(0, 15))};
      n_words  = 50;
      hold_min = 1;
      hold_max = 40;
      ms_lo    = 0;
      ms_hi    = 15;
      idle_on  = (p != 4);
      case (p)
        0: begin
          mode = MODE_SINGLE;
          trig = 1'b0;
        end
        1: begin
          mode = MODE_SINGLE;
          trig = 1'b1;
        end
        2: mode = MODE_REPEAT;
        3: begin
          mode = MODE_REPEAT;
          max_r = '0;
          second_t = '0;
        end
        4: begin
          mode = MODE_LONG;
          trig = 1'b0;
          second_t = '0;
        end
        5: begin
          mode = MODE_LONG;
          trig = 1'b1;
          second_t = first_t + TimeWidth'($urandom_range(1, 60));
        end
        6: begin
          mode = MODE_BAD;
          dcw = TimeWidth'($urandom);
        end
        7: begin
          al = 1'b0;
          trig = 1'b0;
          deb = '0;
          first_t = '0;
          second_t = '0;
          max_r = '0;
          dcw = '0;
          n_words = 260;
          hold_max = 10;
        end
        8: begin
          al = 1'b1;
          trig = 1'b1;
          deb = '1;
          first_t = TimerMax;
          second_t = TimerMax;
          max_r = TimerMax;
          dcw = TimerMax;
          n_words = 260;
          hold_max = 10;
        end
        default: begin
          deb = 8'd1;
          mode = MODE_LONG;
          first_t = TimerMax;
          second_t = TimerMax;
          n_words = 250;
          hold_min = 265;
          hold_max = 300;
          ms_lo = 250;
          ms_hi = 255;
        end
      endcase
      write_reg(CFG_ACTIVE_LEVEL, {15'($urandom), al});
      write_reg(CFG_DEBOUNCE, {8'($urandom), deb});
      write_reg(CFG_PRESS_MODE, {14'($urandom), mode});
      write_reg(CFG_TRIG_RELEASE, {15'($urandom), trig});
      write_reg(CFG_FIRST_TIME, first_t);
      write_reg(CFG_SECOND_TIME, second_t);
      write_reg(CFG_MAX_REPEATS, max_r);
      write_reg(CFG_DCLICK_WINDOW, dcw);
      run_phase(n_words, hold_min, hold_max, ms_lo, ms_hi);
    end

    drain();
    if (mismatches == 0) begin
      $display("button_event_detector regression: pass");
    end else begin
      $display("button_event_detector regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("button_event_detector regression: fail");
    $finish;
  end

endmodule
